// File: design/bbi_pkg.sv
// Package for the Bollinger band indicator: field widths, register indexes,
// reset values and the sequencer state type. No dependencies.
package bbi_pkg;

    localparam int MAX_WINDOW_DEF = 64;
    localparam int PRICE_BITS_DEF = 24;

    localparam int WL_W       = 7;
    localparam int BM_W       = 12;
    localparam int TAG_W      = 32;
    localparam int BAND_W     = 40;
    localparam int MID_W      = 32;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 12;

    localparam logic [WL_W-1:0] WL_RESET = 7'd20;
    localparam logic [BM_W-1:0] BM_RESET = 12'd512;

    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LENGTH   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BAND_MULTIPLIER = 2'd1;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_READ,
        ST_SUMADD,
        ST_MUL,
        ST_SQ_SUB,
        ST_SQ_ADD,
        ST_SS_LOAD,
        ST_DSUB,
        ST_DIV_LOAD,
        ST_DIV,
        ST_SQRT_LOAD,
        ST_SQRT,
        ST_BM_LOAD,
        ST_MID_LOAD,
        ST_UP,
        ST_LO,
        ST_OUT
    } t_state;

endpackage

// File: design/bollinger_band_indicator_top.sv
// Bollinger bands over a sliding price window: one add/subtract unit under a sequencer.
// Depends on bbi_pkg.
// One price word at a time: o_ready is high only while the sequencer is idle, so no word is
// taken before the last one has been worked through; the next word is taken while a result
// waits in the output register. While the window fills, the variance and band steps are skipped.
// The divider and square-root loops make one bit per cycle through the shared adder.
// Reset (synchronous, active low) restores the registers to 20 and 2.0 and clears the series.
module bollinger_band_indicator_top #(
    parameter int MAX_WINDOW = bbi_pkg::MAX_WINDOW_DEF,
    parameter int PRICE_BITS = bbi_pkg::PRICE_BITS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_ready,
    input  logic [PRICE_BITS-1:0]             i_close_price,
    input  logic [bbi_pkg::TAG_W-1:0]         i_time_tag,
    output logic                              o_valid,
    input  logic                              i_ready,
    output logic                              o_band_valid,
    output logic signed [bbi_pkg::BAND_W-1:0] o_upper_band,
    output logic [bbi_pkg::MID_W-1:0]         o_middle_band,
    output logic signed [bbi_pkg::BAND_W-1:0] o_lower_band,
    output logic [bbi_pkg::TAG_W-1:0]         o_result_tag,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [bbi_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [bbi_pkg::CFG_DATA_W-1:0]    i_cfg_data
);
    import bbi_pkg::*;

    localparam int LEN_W   = $clog2(MAX_WINDOW + 1);
    localparam int ADDR_W  = $clog2(MAX_WINDOW);
    localparam int SUM_W   = PRICE_BITS + LEN_W;
    localparam int SQ_W    = 2 * PRICE_BITS + LEN_W;
    localparam int D_W     = 2 * SUM_W;
    localparam int AW_MIN  = 2 * ((D_W + 17) / 2);
    localparam int AW      = (AW_MIN > BAND_W + 2) ? AW_MIN : BAND_W + 2;
    localparam int RT_ITER = AW / 2;
    localparam int DIV1_NB = D_W + 16;
    localparam int DIV2_NB = SUM_W + 8;
    localparam int CNT_W   = $clog2(AW + 1);

    logic [PRICE_BITS-1:0] mem_window [MAX_WINDOW];

    t_state              r_state, n_state, r_ret;
    logic [WL_W-1:0]     r_wl;
    logic [BM_W-1:0]     r_bm;
    logic [ADDR_W-1:0]   r_slot;
    logic [LEN_W-1:0]    r_fill;
    logic [SUM_W-1:0]    r_sum;
    logic [SQ_W-1:0]     r_sq;
    logic                r_evict, r_res_valid;
    logic [PRICE_BITS-1:0] r_price, r_rd;
    logic [TAG_W-1:0]    r_tag;
    logic [AW-1:0]       r_acc, r_ma, r_mb, r_num, r_rem, r_dv, r_delta, r_up, r_lo;
    logic [D_W-1:0]      r_lq;
    logic [CNT_W-1:0]    r_cnt;

    logic [LEN_W-1:0]    len;
    logic [LEN_W-1:0]    slot_inc, fill_new;
    logic                in_acc, cfg_acc, out_free;
    logic [AW-1:0]       alu_a, alu_b, alu_y;
    logic                alu_sub, alu_ge;
    logic [AW:0]         alu_full;
    logic [AW-1:0]       div_trial, sqrt_trial;

    always_comb begin
        if (r_wl == '0) begin
            len = LEN_W'(1);
        end else if (32'(r_wl) > 32'(MAX_WINDOW)) begin
            len = LEN_W'(MAX_WINDOW);
        end else begin
            len = LEN_W'(r_wl);
        end
    end

    // A pending register write takes precedence over a new price word.
    assign o_ready     = (r_state == ST_IDLE) && !i_cfg_valid;
    assign o_cfg_ready = (r_state == ST_IDLE);
    assign in_acc      = i_valid && o_ready;
    assign cfg_acc     = i_cfg_valid && o_cfg_ready;
    assign out_free    = !o_valid || i_ready;
    assign slot_inc    = LEN_W'(r_slot) + LEN_W'(1);
    assign fill_new    = (r_fill < len) ? r_fill + LEN_W'(1) : r_fill;
    assign div_trial   = {r_rem[AW-2:0], r_num[AW-1]};
    assign sqrt_trial  = {r_rem[AW-3:0], r_num[AW-1:AW-2]};

    // Shared add/subtract unit; the carry out is the greater-or-equal flag.
    always_comb begin
        alu_a   = '0;
        alu_b   = '0;
        alu_sub = 1'b0;
        case (r_state)
            ST_READ: begin
                alu_a = AW'(r_sum); alu_b = AW'(r_rd); alu_sub = 1'b1;
            end
            ST_SUMADD: begin
                alu_a = AW'(r_sum); alu_b = AW'(r_price);
            end
            ST_MUL: begin
                alu_a = r_acc; alu_b = r_mb[0] ? r_ma : '0;
            end
            ST_SQ_SUB: begin
                alu_a = AW'(r_sq); alu_b = r_acc; alu_sub = 1'b1;
            end
            ST_SQ_ADD: begin
                alu_a = AW'(r_sq); alu_b = r_acc;
            end
            ST_DSUB: begin
                alu_a = AW'(r_lq); alu_b = r_acc; alu_sub = 1'b1;
            end
            ST_DIV: begin
                alu_a = div_trial; alu_b = r_dv; alu_sub = 1'b1;
            end
            ST_SQRT: begin
                alu_a = sqrt_trial; alu_b = {r_acc[AW-3:0], 2'b01}; alu_sub = 1'b1;
            end
            ST_UP: begin
                alu_a = r_num; alu_b = r_delta;
            end
            ST_LO: begin
                alu_a = r_num; alu_b = r_delta; alu_sub = 1'b1;
            end
            default: begin
                alu_a = '0;
            end
        endcase
    end

    assign alu_full = {1'b0, alu_a} + {1'b0, (alu_sub ? ~alu_b : alu_b)} + (AW+1)'(alu_sub);
    assign alu_y    = alu_full[AW-1:0];
    assign alu_ge   = alu_full[AW];

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE:      if (in_acc) n_state = ST_READ;
            ST_READ:      n_state = ST_SUMADD;
            ST_SUMADD:    n_state = ST_MUL;
            ST_MUL:       if (r_mb == '0) n_state = r_ret;
            ST_SQ_SUB:    n_state = ST_MUL;
            ST_SQ_ADD:    n_state = r_res_valid ? ST_MUL : ST_OUT;
            ST_SS_LOAD:   n_state = ST_MUL;
            ST_DSUB:      n_state = ST_MUL;
            ST_DIV_LOAD:  n_state = ST_DIV;
            ST_DIV:       if (r_cnt == '0) n_state = r_ret;
            ST_SQRT_LOAD: n_state = ST_SQRT;
            ST_SQRT:      if (r_cnt == '0) n_state = ST_BM_LOAD;
            ST_BM_LOAD:   n_state = ST_MUL;
            ST_MID_LOAD:  n_state = ST_DIV;
            ST_UP:        n_state = ST_LO;
            ST_LO:        n_state = ST_OUT;
            ST_OUT:       if (out_free) n_state = ST_IDLE;
            default:      n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_rd               <= mem_window[r_slot];
            mem_window[r_slot] <= i_close_price;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_wl    <= WL_RESET;
            r_bm    <= BM_RESET;
            r_slot  <= '0;
            r_fill  <= '0;
            r_sum   <= '0;
            r_sq    <= '0;
            o_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (cfg_acc && (i_cfg_index == REG_WINDOW_LENGTH ||
                            i_cfg_index == REG_BAND_MULTIPLIER)) begin
                if (i_cfg_index == REG_WINDOW_LENGTH) begin
                    r_wl <= i_cfg_data[WL_W-1:0];
                end else begin
                    r_bm <= i_cfg_data[BM_W-1:0];
                end
                r_slot <= '0;
                r_fill <= '0;
                r_sum  <= '0;
                r_sq   <= '0;
            end
            if (in_acc) begin
                r_slot <= (slot_inc >= len) ? '0 : slot_inc[ADDR_W-1:0];
                r_fill <= fill_new;
            end
            if ((r_state == ST_READ && r_evict) || r_state == ST_SUMADD) begin
                r_sum <= alu_y[SUM_W-1:0];
            end
            if (r_state == ST_SQ_SUB || r_state == ST_SQ_ADD) begin
                r_sq <= alu_y[SQ_W-1:0];
            end
            if (r_state == ST_OUT && out_free) begin
                o_valid <= 1'b1;
            end else if (i_ready) begin
                o_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_price     <= i_close_price;
            r_tag       <= i_time_tag;
            r_evict     <= (r_fill >= len);
            r_res_valid <= (fill_new >= len);
        end
        case (r_state)
            ST_SUMADD: begin
                r_acc <= '0;
                if (r_evict) begin
                    r_ma  <= AW'(r_rd);
                    r_mb  <= AW'(r_rd);
                    r_ret <= ST_SQ_SUB;
                end else begin
                    r_ma  <= AW'(r_price);
                    r_mb  <= AW'(r_price);
                    r_ret <= ST_SQ_ADD;
                end
            end
            ST_MUL: begin
                if (r_mb != '0) begin
                    r_acc <= alu_y;
                    r_ma  <= r_ma << 1;
                    r_mb  <= r_mb >> 1;
                end
            end
            ST_SQ_SUB: begin
                r_acc <= '0;
                r_ma  <= AW'(r_price);
                r_mb  <= AW'(r_price);
                r_ret <= ST_SQ_ADD;
            end
            ST_SQ_ADD: begin
                r_acc <= '0;
                r_ma  <= AW'(alu_y[SQ_W-1:0]);
                r_mb  <= AW'(len);
                r_ret <= ST_SS_LOAD;
            end
            ST_SS_LOAD: begin
                r_lq  <= r_acc[D_W-1:0];
                r_acc <= '0;
                r_ma  <= AW'(r_sum);
                r_mb  <= AW'(r_sum);
                r_ret <= ST_DSUB;
            end
            ST_DSUB: begin
                r_lq  <= alu_ge ? alu_y[D_W-1:0] : '0;
                r_acc <= '0;
                r_ma  <= AW'(len);
                r_mb  <= AW'(len);
                r_ret <= ST_DIV_LOAD;
            end
            ST_DIV_LOAD: begin
                r_dv  <= r_acc;
                r_num <= AW'(r_lq) << (AW - D_W);
                r_rem <= '0;
                r_cnt <= CNT_W'(DIV1_NB);
                r_ret <= ST_SQRT_LOAD;
            end
            ST_DIV: begin
                if (r_cnt != '0) begin
                    r_rem <= alu_ge ? alu_y : div_trial;
                    r_num <= {r_num[AW-2:0], alu_ge};
                    r_cnt <= r_cnt - CNT_W'(1);
                end
            end
            ST_SQRT_LOAD: begin
                r_rem <= '0;
                r_acc <= '0;
                r_cnt <= CNT_W'(RT_ITER);
            end
            ST_SQRT: begin
                if (r_cnt != '0) begin
                    r_rem <= alu_ge ? alu_y : sqrt_trial;
                    r_acc <= {r_acc[AW-2:0], alu_ge};
                    r_num <= r_num << 2;
                    r_cnt <= r_cnt - CNT_W'(1);
                end
            end
            ST_BM_LOAD: begin
                r_ma  <= r_acc;
                r_mb  <= AW'(r_bm);
                r_acc <= '0;
                r_ret <= ST_MID_LOAD;
            end
            ST_MID_LOAD: begin
                r_delta <= r_acc >> 8;
                r_dv    <= AW'(len);
                r_num   <= AW'(r_sum) << (AW - SUM_W);
                r_rem   <= '0;
                r_cnt   <= CNT_W'(DIV2_NB);
                r_ret   <= ST_UP;
            end
            ST_UP: begin
                r_up <= alu_y;
            end
            ST_LO: begin
                r_lo <= alu_y;
            end
            ST_OUT: begin
                if (out_free) begin
                    o_band_valid  <= r_res_valid;
                    o_result_tag  <= r_tag;
                    o_upper_band  <= r_res_valid ? BAND_W'(r_up) : '0;
                    o_lower_band  <= r_res_valid ? BAND_W'(r_lo) : '0;
                    o_middle_band <= r_res_valid ? MID_W'(r_num) : '0;
                end
            end
            default: begin
                r_cnt <= r_cnt;
            end
        endcase
    end

endmodule

// File: design/bbi_chk.sv
// Port-level checker for the Bollinger band indicator, bound to the top level.
// Depends on bbi_pkg and bollinger_band_indicator_top.
module bbi_chk (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              i_valid,
    input logic                              o_ready,
    input logic                              o_valid,
    input logic                              i_ready,
    input logic                              o_band_valid,
    input logic signed [bbi_pkg::BAND_W-1:0] o_upper_band,
    input logic [bbi_pkg::MID_W-1:0]         o_middle_band,
    input logic signed [bbi_pkg::BAND_W-1:0] o_lower_band
);
    import bbi_pkg::*;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid)
        else $error("result word dropped before it was taken");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready |=> !o_ready)
        else $error("input ready while a word is being worked on");

    a_zero_bands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_band_valid |->
        o_upper_band == '0 && o_middle_band == '0 && o_lower_band == '0)
        else $error("bands not zero while the window fills");

    a_symmetric: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_band_valid |->
        BAND_W'(o_upper_band + o_lower_band) == BAND_W'({o_middle_band, 1'b0}))
        else $error("bands not symmetric about the middle band");

    a_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_band_valid |-> o_upper_band >= o_lower_band)
        else $error("upper band below lower band");

endmodule

bind bollinger_band_indicator_top bbi_chk u_bbi_chk (.*);

// File: tb/tb_top.sv
`timescale 1ns / 1ps
// Self-checking testbench for the Bollinger band indicator: directed table, then random
// price streams under several window settings. Depends on bbi_pkg and the top module.
module tb_top;
    import bbi_pkg::*;

    localparam int NUM_RANDOM = 1750;
    localparam int CYCLE_LIMIT = 3000000;
    localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED = 2'd3;

    typedef struct packed {
        logic                     band_valid;
        logic signed [BAND_W-1:0] upper;
        logic [MID_W-1:0]         middle;
        logic signed [BAND_W-1:0] lower;
        logic [TAG_W-1:0]         tag;
    } t_bands;

    typedef struct {
        logic [23:0]     price;
        logic [TAG_W-1:0] tag;
        bit              has_exp;
        t_bands          exp;
    } t_row;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_valid = 1'b0;
    logic o_ready;
    logic [23:0] i_close_price = '0;
    logic [TAG_W-1:0] i_time_tag = '0;
    logic o_valid;
    logic i_ready = 1'b0;
    logic o_band_valid;
    logic signed [BAND_W-1:0] o_upper_band;
    logic [MID_W-1:0] o_middle_band;
    logic signed [BAND_W-1:0] o_lower_band;
    logic [TAG_W-1:0] o_result_tag;
    logic i_cfg_valid = 1'b0;
    logic o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    bollinger_band_indicator_top dut (.*);

    always #2 i_clk = ~i_clk;

    // Predictor state.
    logic [6:0]  win_len;
    logic [11:0] band_mult;
    logic [23:0] price_ring[64];
    int unsigned ring_slot, held;
    logic [63:0] price_sum, square_sum;

    t_bands band_queue[$];
    t_row   table_rows[$];
    int unsigned errors = 0, words_out = 0, valid_out = 0, cycles = 0;
    bit idle_enable = 1'b1, hold_off = 1'b0, sending_done = 1'b0;

    function automatic logic [63:0] isqrt(logic [63:0] v);
        logic [63:0] root, bitv;
        root = 0;
        bitv = 64'd1 << 62;
        while (bitv > v) bitv >>= 2;
        while (bitv != 0) begin
            if (v >= root + bitv) begin
                v -= root + bitv;
                root = (root >> 1) + bitv;
            end else begin
                root >>= 1;
            end
            bitv >>= 2;
        end
        return root;
    endfunction

    function automatic void restart_window();
        ring_slot = 0;
        held = 0;
        price_sum = 0;
        square_sum = 0;
    endfunction

    function automatic t_bands predict_bands(logic [23:0] price, logic [TAG_W-1:0] tag);
        t_bands r;
        logic [63:0] len, d, a, b, q, rem, scaled, sd, delta, mid;
        len = (win_len == 0) ? 1 : (win_len > 64) ? 64 : win_len;
        if (held >= len) begin
            price_sum -= price_ring[ring_slot];
            square_sum -= 64'(price_ring[ring_slot]) * price_ring[ring_slot];
        end
        price_ring[ring_slot] = price;
        price_sum += price;
        square_sum += 64'(price) * price;
        ring_slot = (ring_slot + 1 >= len) ? 0 : ring_slot + 1;
        if (held < len) held++;
        r = '0;
        r.tag = tag;
        if (held >= len) begin
            a = len * square_sum;
            b = price_sum * price_sum;
            d = (a > b) ? a - b : 0;
            q = d / (len * len);
            rem = d % (len * len);
            scaled = (q << 16) + ((rem << 16) / (len * len));
            sd = isqrt(scaled);
            delta = (64'(band_mult) * sd) >> 8;
            mid = (price_sum << 8) / len;
            r.band_valid = 1'b1;
            r.upper = BAND_W'(mid + delta);
            r.middle = MID_W'(mid);
            r.lower = BAND_W'(mid - delta);
        end
        return r;
    endfunction

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        $display("MISMATCH %s tag=%h got=%h want=%h", what, o_result_tag, got, want);
        errors++;
    endtask

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles.", cycles);
            $display("DONE: errors detected");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        t_bands e;
        if (i_rst_n && o_valid && i_ready) begin
            words_out++;
            if (band_queue.size() == 0) begin
                report_mismatch("unexpected word", 64'(o_result_tag), 0);
            end else begin
                e = band_queue.pop_front();
                if (e.band_valid) valid_out++;
                if (o_band_valid !== e.band_valid)
                    report_mismatch("band_valid", 64'(o_band_valid), 64'(e.band_valid));
                if (o_upper_band !== e.upper)
                    report_mismatch("upper_band", 64'(o_upper_band), 64'(e.upper));
                if (o_middle_band !== e.middle)
                    report_mismatch("middle_band", 64'(o_middle_band), 64'(e.middle));
                if (o_lower_band !== e.lower)
                    report_mismatch("lower_band", 64'(o_lower_band), 64'(e.lower));
                if (o_result_tag !== e.tag)
                    report_mismatch("result_tag", 64'(o_result_tag), 64'(e.tag));
            end
        end
    end

    always @(negedge i_clk) begin
        i_ready <= !hold_off && (!idle_enable || $urandom_range(99) >= 38);
    end

    // Long receiver hold-off so that the block fills and stalls its input.
    initial begin
        @(posedge i_rst_n);
        repeat (400) @(posedge i_clk);
        hold_off = 1'b1;
        repeat (3000) @(posedge i_clk);
        hold_off = 1'b0;
    end

    task automatic send_price(logic [23:0] price, logic [TAG_W-1:0] tag, bit has_exp,
                              t_bands exp);
        t_bands p;
        while (idle_enable && $urandom_range(99) < 38) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid <= 1'b1;
        i_close_price <= price;
        i_time_tag <= tag;
        p = predict_bands(price, tag);
        band_queue.push_back(has_exp ? exp : p);
        do @(posedge i_clk); while (!o_ready);
        @(negedge i_clk);
    endtask

    task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
        i_valid <= 1'b0;
        while (band_queue.size() != 0) @(negedge i_clk);
        repeat (300) @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
        if (idx == REG_WINDOW_LENGTH) begin
            win_len = value[6:0];
            restart_window();
        end else if (idx == REG_BAND_MULTIPLIER) begin
            band_mult = value;
            restart_window();
        end
    endtask

    function automatic t_row mk(logic [23:0] p, logic [TAG_W-1:0] t, bit he, t_bands e);
        t_row r;
        r.price = p;
        r.tag = t;
        r.has_exp = he;
        r.exp = e;
        return r;
    endfunction

    initial begin
        t_bands e0, e1;
        int unsigned phase, n, burst;
        logic [23:0] base;
        logic [11:0] lens[8];
        lens = '{12'd1, 12'd0, 12'd64, 12'd100, 12'd2, 12'd5, 12'd20, 12'd33};
        win_len = WL_RESET;
        band_mult = BM_RESET;
        restart_window();
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Reset window of 20: nineteen invalid words, then a flat window.
        for (int i = 0; i < 19; i++) begin
            e0 = '0;
            e0.tag = 32'(i);
            table_rows.push_back(mk(24'd1000, 32'(i), 1'b1, e0));
        end
        e1 = '0;
        e1.band_valid = 1'b1;
        e1.upper = 40'd256000;
        e1.middle = 32'd256000;
        e1.lower = 40'd256000;
        e1.tag = 32'hFFFF_FFFF;
        table_rows.push_back(mk(24'd1000, 32'hFFFF_FFFF, 1'b1, e1));
        table_rows.push_back(mk(24'hFFFFFF, 32'h0, 1'b0, e1));
        table_rows.push_back(mk(24'h0, 32'hAAAA_5555, 1'b0, e1));
        table_rows.push_back(mk(24'hFFFFFF, 32'h5555_AAAA, 1'b0, e1));
        foreach (table_rows[i])
            send_price(table_rows[i].price, table_rows[i].tag, table_rows[i].has_exp,
                       table_rows[i].exp);

        // Extreme multiplier with maximum spread, then an unmapped register index.
        write_register(REG_BAND_MULTIPLIER, 12'hFFF);
        write_register(REG_WINDOW_LENGTH, 12'd2);
        send_price(24'hFFFFFF, 32'h1, 1'b0, e1);
        send_price(24'h0, 32'h2, 1'b0, e1);
        send_price(24'hFFFFFF, 32'h3, 1'b0, e1);
        write_register(REG_UNMAPPED, 12'hABC);
        send_price(24'h0, 32'h4, 1'b0, e1);

        n = 0;
        phase = 0;
        while (n < NUM_RANDOM) begin
            write_register(REG_WINDOW_LENGTH, lens[phase % 8]);
            write_register(REG_BAND_MULTIPLIER,
                           (phase % 4 == 0) ? 12'd0 : (phase % 4 == 1) ? 12'hFFF :
                           12'($urandom));
            idle_enable = (phase % 5 != 3);
            burst = 150 + $urandom_range(100);
            base = 24'($urandom);
            for (int k = 0; k < burst && n < NUM_RANDOM; k++, n++) begin
                case ($urandom_range(3))
                    0: send_price(24'($urandom), $urandom, 1'b0, e1);
                    1: send_price($urandom_range(1) ? 24'hFFFFFF : 24'h0, $urandom, 1'b0, e1);
                    default: send_price(base + 24'($urandom_range(2000)), $urandom, 1'b0, e1);
                endcase
            end
            phase++;
        end
        idle_enable = 1'b1;
        i_valid <= 1'b0;

        while (band_queue.size() != 0) @(negedge i_clk);
        repeat (400) @(posedge i_clk);
        $display("Covered %0d result words (%0d with full windows) over %0d settings.",
                 words_out, valid_out, phase + 3);
        if (errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end
endmodule
